// ===== sv/circular_doubly_linked_list_engine_top_defines.svh =====
// assertion macros shared by the engine
`ifndef CIRCULAR_DOUBLY_LINKED_LIST_ENGINE_TOP_DEFINES_SVH
`define CIRCULAR_DOUBLY_LINKED_LIST_ENGINE_TOP_DEFINES_SVH
// assert that a condition implies a consequence on the same edge
`define CDL_ASSERT_IMP(lbl, clk, rst_n, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");
// assert that a condition implies a consequence on the next edge
`define CDL_ASSERT_NEXT(lbl, clk, rst_n, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== sv/cdll_pkg.sv =====
package cdll_pkg;
    localparam int unsigned OP_BITS = 3;
    localparam int unsigned WORD_BITS = 32;
    localparam int unsigned ST_BITS = 3;

    typedef enum logic [OP_BITS-1:0] {
        OP_CREATE  = 3'd0,
        OP_LIST    = 3'd1,
        OP_INS_FRT = 3'd2,
        OP_INS_BCK = 3'd3,
        OP_DEL_FRT = 3'd4,
        OP_DEL_BCK = 3'd5,
        OP_DEL_AFT = 3'd6,
        OP_CLEAR   = 3'd7
    } t_op;

    typedef enum logic [ST_BITS-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_HEAD     = 3'd4
    } t_status;

    typedef struct packed {
        logic [OP_BITS-1:0]   op;
        logic signed [WORD_BITS-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] item_value;
        logic [ST_BITS-1:0]   status;
        logic                 last;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RESET_POOL,
        S_INS_HEAD,
        S_INS_LINK,
        S_DEL_READ,
        S_DEL_LINK,
        S_LIST_RD,
        S_LIST_EMIT,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_DONE
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic   latch_in;
        logic   pool_reset;
        logic   ins_alloc;
        logic   ins_link;
        logic   del_sel_head;
        logic   del_sel_tail;
        logic   del_sel_cur;
        logic   del_read;
        logic   del_link;
        logic   walk_start;
        logic   walk_read;
        logic   walk_step;
        logic   emit;
        logic   emit_item;
        logic   emit_last;
        logic [ST_BITS-1:0] emit_status;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic   empty;
        logic   full;
        logic   walk_last;
        logic   match;
        logic   victim_is_head;
    } t_stat;
endpackage

// ===== sv/cdll_ctrl.sv =====
`include "circular_doubly_linked_list_engine_top_defines.svh"
module cdll_ctrl
    import cdll_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [OP_BITS-1:0] i_op,
    input  t_stat            i_stat,
    output t_cmd             o_cmd,
    output logic             o_busy
);
    t_state r_state, n_state;
    t_op    r_op, n_op;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_CREATE;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        o_cmd   = '0;
        o_busy  = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op = t_op'(i_op);
                    o_cmd.latch_in = 1'b1;
                    case (t_op'(i_op))
                        OP_CREATE: n_state = S_RESET_POOL;
                        OP_LIST: begin
                            if (i_stat.empty) begin
                                o_cmd.emit = 1'b1;
                                o_cmd.emit_last = 1'b1;
                                o_cmd.emit_status = ST_EMPTY;
                            end else begin
                                o_cmd.walk_start = 1'b1;
                                n_state = S_LIST_RD;
                            end
                        end
                        OP_INS_FRT, OP_INS_BCK: begin
                            if (i_stat.full) begin
                                o_cmd.emit = 1'b1;
                                o_cmd.emit_last = 1'b1;
                                o_cmd.emit_status = ST_FULL;
                            end else begin
                                n_state = S_INS_HEAD;
                            end
                        end
                        OP_DEL_FRT, OP_DEL_BCK: begin
                            if (i_stat.empty) begin
                                o_cmd.emit = 1'b1;
                                o_cmd.emit_last = 1'b1;
                                o_cmd.emit_status = ST_EMPTY;
                            end else begin
                                o_cmd.del_sel_head = (t_op'(i_op) == OP_DEL_FRT);
                                o_cmd.del_sel_tail = (t_op'(i_op) == OP_DEL_BCK);
                                n_state = S_DEL_READ;
                            end
                        end
                        OP_DEL_AFT: begin
                            if (i_stat.empty) begin
                                o_cmd.emit = 1'b1;
                                o_cmd.emit_last = 1'b1;
                                o_cmd.emit_status = ST_EMPTY;
                            end else begin
                                o_cmd.walk_start = 1'b1;
                                n_state = S_SRCH_RD;
                            end
                        end
                        default: begin
                            o_cmd.emit = 1'b1;
                            o_cmd.emit_last = 1'b1;
                            if (i_stat.empty) begin
                                o_cmd.emit_status = ST_EMPTY;
                            end else begin
                                o_cmd.pool_reset = 1'b1;
                                o_cmd.emit_status = ST_OK;
                            end
                        end
                    endcase
                end
            end
            S_RESET_POOL: begin
                o_cmd.pool_reset = 1'b1;
                n_state = S_INS_HEAD;
            end
            // read head's prev link and allocate
            S_INS_HEAD: begin
                o_cmd.ins_alloc = 1'b1;
                n_state = S_INS_LINK;
            end
            S_INS_LINK: begin
                o_cmd.ins_link = 1'b1;
                o_cmd.emit = 1'b1;
                o_cmd.emit_last = 1'b1;
                o_cmd.emit_status = ST_OK;
                n_state = S_IDLE;
            end
            S_DEL_READ: begin
                o_cmd.del_read = 1'b1;
                n_state = S_DEL_LINK;
            end
            S_DEL_LINK: begin
                o_cmd.del_link = 1'b1;
                o_cmd.emit = 1'b1;
                o_cmd.emit_last = 1'b1;
                o_cmd.emit_status = ST_OK;
                n_state = S_IDLE;
            end
            // list walk: read node, then emit and step
            S_LIST_RD: begin
                o_cmd.walk_read = 1'b1;
                n_state = S_LIST_EMIT;
            end
            S_LIST_EMIT: begin
                o_cmd.emit = 1'b1;
                o_cmd.emit_item = 1'b1;
                o_cmd.emit_status = ST_OK;
                o_cmd.walk_step = 1'b1;
                if (i_stat.walk_last) begin
                    o_cmd.emit_last = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_LIST_RD;
                end
            end
            S_SRCH_RD: begin
                o_cmd.walk_read = 1'b1;
                n_state = S_SRCH_CHK;
            end
            S_SRCH_CHK: begin
                o_cmd.walk_step = 1'b1;
                if (i_stat.match) begin
                    if (i_stat.victim_is_head) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.emit_last = 1'b1;
                        o_cmd.emit_status = ST_HEAD;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.del_sel_cur = 1'b1;
                        n_state = S_DEL_READ;
                    end
                end else if (i_stat.walk_last) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    o_cmd.emit_status = ST_NOTFOUND;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SRCH_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    `CDL_ASSERT_IMP(a_emit_busy_or_start, i_clk, i_rst_n, o_cmd.emit, o_busy || i_start)
    `CDL_ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, o_cmd.emit && o_cmd.emit_last, r_state == S_IDLE)
    `CDL_ASSERT_IMP(a_item_only_list, i_clk, i_rst_n, o_cmd.emit_item, r_op == OP_LIST)
endmodule

// ===== sv/cdll_dp.sv =====
`include "circular_doubly_linked_list_engine_top_defines.svh"
module cdll_dp
    import cdll_pkg::*;
#(
    parameter int unsigned CAPACITY  = 16,
    parameter int unsigned DATA_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_in,
    input  t_cmd      i_cmd,
    output t_stat     o_stat,
    output t_out_word o_out,
    output logic      o_out_valid
);
    localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    logic [DATA_BITS-1:0] m_value [CAPACITY];
    logic [IW-1:0]        m_next  [CAPACITY];
    logic [IW-1:0]        m_prev  [CAPACITY];
    logic [IW-1:0]        r_free  [CAPACITY];

    logic [IW-1:0] r_head, r_cur, r_tail, r_new, r_vprev, r_vnext, r_victim;
    logic [CW-1:0] r_count, r_top, r_walk;
    logic [DATA_BITS-1:0] r_key, r_rd_value;
    logic [IW-1:0] r_rd_next;
    logic          r_front;
    t_out_word r_out;
    logic      r_out_valid;

    logic [IW-1:0] w_top_idx;
    logic [IW-1:0] w_del_n;
    logic [CW-1:0] w_top_dec;

    assign w_top_dec = r_top - CW'(1);
    assign w_top_idx = w_top_dec[IW-1:0];
    assign w_del_n   = r_victim;

    // control state: head, count, free stack
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_top   <= CW'(CAPACITY);
            for (int i = 0; i < CAPACITY; i++) begin
                r_free[i] <= IW'(i);
            end
        end else begin
            if (i_cmd.pool_reset) begin
                r_head  <= '0;
                r_count <= '0;
                r_top   <= CW'(CAPACITY);
                for (int i = 0; i < CAPACITY; i++) begin
                    r_free[i] <= IW'(i);
                end
            end
            if (i_cmd.ins_alloc) begin
                r_top <= w_top_dec;
            end
            if (i_cmd.ins_link) begin
                r_count <= r_count + CW'(1);
                if (r_count == '0 || r_front) begin
                    r_head <= r_new;
                end
            end
            if (i_cmd.del_link) begin
                r_free[r_top[IW-1:0]] <= w_del_n;
                r_top <= r_top + CW'(1);
                if (r_count <= CW'(1)) begin
                    r_count <= '0;
                    r_head  <= '0;
                end else begin
                    r_count <= r_count - CW'(1);
                    if (w_del_n == r_head) begin
                        r_head <= r_vnext;
                    end
                end
            end
        end
    end

    // node memory and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_key   <= DATA_BITS'(signed'(i_in.value));
            r_front <= (t_op'(i_in.op) == OP_INS_FRT);
        end
        if (i_cmd.ins_alloc) begin
            r_new  <= r_free[w_top_idx];
            r_tail <= m_prev[r_head];
            m_value[r_free[w_top_idx]] <= r_key;
        end
        if (i_cmd.ins_link) begin
            if (r_count == '0) begin
                m_next[r_new] <= r_new;
                m_prev[r_new] <= r_new;
            end else begin
                m_next[r_new]  <= r_head;
                m_prev[r_new]  <= r_tail;
                m_next[r_tail] <= r_new;
                m_prev[r_head] <= r_new;
            end
        end
        if (i_cmd.del_sel_head) begin
            r_victim <= r_head;
        end
        if (i_cmd.del_sel_tail) begin
            r_victim <= m_prev[r_head];
        end
        if (i_cmd.del_sel_cur) begin
            r_victim <= r_rd_next;
        end
        if (i_cmd.del_read) begin
            r_vprev <= m_prev[r_victim];
            r_vnext <= m_next[r_victim];
        end
        if (i_cmd.del_link && r_count > CW'(1)) begin
            m_next[r_vprev] <= r_vnext;
            m_prev[r_vnext] <= r_vprev;
        end
        if (i_cmd.walk_start) begin
            r_cur  <= r_head;
            r_walk <= CW'(1);
        end
        if (i_cmd.walk_read) begin
            r_rd_value <= m_value[r_cur];
            r_rd_next  <= m_next[r_cur];
        end
        if (i_cmd.walk_step) begin
            r_cur  <= r_rd_next;
            r_walk <= r_walk + CW'(1);
        end
    end

    // status back to the controller
    assign o_stat.empty          = (r_count == '0);
    assign o_stat.full           = (r_top == '0);
    assign o_stat.walk_last      = (r_walk >= r_count);
    assign o_stat.match          = (r_rd_value == r_key);
    assign o_stat.victim_is_head = (r_rd_next == r_head);

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.emit;
        end
        if (i_cmd.emit) begin
            r_out.item_value <= i_cmd.emit_item
                ? WORD_BITS'(signed'(r_rd_value)) : '0;
            r_out.status <= i_cmd.emit_status;
            r_out.last   <= i_cmd.emit_last;
        end
    end

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;

    // the count still lags the pop while an insert links
    `CDL_ASSERT_IMP(a_count_le_cap, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY))
    `CDL_ASSERT_IMP(a_pool_balance, i_clk, i_rst_n, !i_cmd.ins_link, r_count + r_top == CW'(CAPACITY))
    `CDL_ASSERT_NEXT(a_alloc_pops, i_clk, i_rst_n, i_cmd.ins_alloc, r_top == $past(r_top) - CW'(1))
endmodule

// ===== sv/circular_doubly_linked_list_engine_top.sv =====
// Circular doubly linked list engine over a pool of CAPACITY nodes. Raise
// start with a word while busy is low. Every operation returns one result
// word on o_out, marked by o_done for one cycle, except list, which returns
// one word per node from the head, the final one with last set. The receiver
// cannot stall, so results must be taken as they appear. Clear and failed
// operations end in the accept cycle; create resets the pool and inserts;
// inserts allocate then link; deletes read the victim's links then unlink;
// list and delete after walk one node at a time, and a match may unlink the
// next node. Each result appears the cycle after its operation ends.
module circular_doubly_linked_list_engine_top
    import cdll_pkg::*;
#(
    parameter int unsigned CAPACITY  = 16,
    parameter int unsigned DATA_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_word  i_in,
    output t_out_word o_out,
    output logic      o_done
);
    t_cmd  w_cmd;
    t_stat w_stat;

    cdll_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_in.op),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    cdll_dp #(
        .CAPACITY  (CAPACITY),
        .DATA_BITS (DATA_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out       (o_out),
        .o_out_valid (o_done)
    );
endmodule

// ===== tb/sv/cdll_checker.sv =====
module cdll_checker
    import cdll_pkg::*;
#(
    parameter int unsigned CAPACITY = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  logic      i_busy,
    input  t_in_word  i_in,
    input  t_out_word i_out,
    input  logic      i_done,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_words_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow copy of the list
    logic signed [31:0] shadow_value [CAPACITY];
    logic [3:0]         shadow_next  [CAPACITY];
    logic [3:0]         shadow_prev  [CAPACITY];
    logic [3:0]         shadow_free  [CAPACITY];
    int unsigned        shadow_head;
    int unsigned        shadow_count;
    int unsigned        shadow_top;
    t_out_word          expected_words [$];

    function automatic t_out_word mk_word(logic signed [31:0] v, t_status st, logic lst);
        t_out_word w;
        w.item_value = v;
        w.status     = st;
        w.last       = lst;
        return w;
    endfunction

    task automatic pool_empty();
        for (int i = 0; i < CAPACITY; i++) shadow_free[i] = i[3:0];
        shadow_top   = CAPACITY;
        shadow_count = 0;
        shadow_head  = 0;
    endtask

    task automatic node_insert(logic signed [31:0] v, bit front, output t_status st);
        int unsigned n, h, t;
        if (shadow_top == 0 || shadow_count >= CAPACITY) begin
            st = ST_FULL;
            return;
        end
        shadow_top--;
        n = shadow_free[shadow_top];
        shadow_value[n] = v;
        if (shadow_count == 0) begin
            shadow_next[n] = n[3:0];
            shadow_prev[n] = n[3:0];
            shadow_head    = n;
        end else begin
            h = shadow_head;
            t = shadow_prev[h];
            shadow_next[n] = h[3:0];
            shadow_prev[n] = t[3:0];
            shadow_next[t] = n[3:0];
            shadow_prev[h] = n[3:0];
            if (front) shadow_head = n;
        end
        shadow_count++;
        st = ST_OK;
    endtask

    task automatic node_unlink(int unsigned n);
        int unsigned p, q;
        if (shadow_count <= 1) begin
            shadow_count = 0;
            shadow_head  = 0;
        end else begin
            p = shadow_prev[n];
            q = shadow_next[n];
            shadow_next[p] = q[3:0];
            shadow_prev[q] = p[3:0];
            if (n == shadow_head) shadow_head = q;
            shadow_count--;
        end
        if (shadow_top < CAPACITY) begin
            shadow_free[shadow_top] = n[3:0];
            shadow_top++;
        end
    endtask

    // apply one command word to the shadow list and queue its results
    task automatic apply_command(t_in_word w);
        t_status     st;
        int unsigned n;
        st = ST_OK;
        case (t_op'(w.op))
            OP_CREATE: begin
                pool_empty();
                node_insert(w.value, 1'b0, st);
            end
            OP_LIST: begin
                if (shadow_count == 0) begin
                    expected_words.push_back(mk_word(0, ST_EMPTY, 1'b1));
                end else begin
                    n = shadow_head;
                    for (int i = 0; i < shadow_count; i++) begin
                        expected_words.push_back(mk_word(shadow_value[n], ST_OK,
                            i + 1 == shadow_count));
                        n = shadow_next[n];
                    end
                end
                return;
            end
            OP_INS_FRT, OP_INS_BCK: node_insert(w.value, w.op == OP_INS_FRT, st);
            OP_DEL_FRT, OP_DEL_BCK: begin
                if (shadow_count == 0) st = ST_EMPTY;
                else if (w.op == OP_DEL_FRT) node_unlink(shadow_head);
                else node_unlink(shadow_prev[shadow_head]);
            end
            OP_DEL_AFT: begin
                if (shadow_count == 0) begin
                    st = ST_EMPTY;
                end else begin
                    st = ST_NOTFOUND;
                    n  = shadow_head;
                    for (int i = 0; i < shadow_count; i++) begin
                        if (shadow_value[n] == w.value) begin
                            if (shadow_next[n] == shadow_head) st = ST_HEAD;
                            else begin
                                node_unlink(shadow_next[n]);
                                st = ST_OK;
                            end
                            break;
                        end
                        n = shadow_next[n];
                    end
                end
            end
            default: begin
                if (shadow_count == 0) st = ST_EMPTY;
                else pool_empty();
            end
        endcase
        expected_words.push_back(mk_word(0, st, 1'b1));
    endtask

    // watch both channels
    always @(posedge i_clk) begin
        t_out_word exp_w;
        int        errs;
        errs = 0;
        if (!i_rst_n) begin
            pool_empty();
            expected_words.delete();
            o_fail_count <= 0;
            o_words_seen <= 0;
        end else begin
            if (i_done) begin
                o_words_seen <= o_words_seen + 1;
                if (expected_words.size() == 0) begin
                    $error("result word with nothing expected");
                    errs++;
                end else begin
                    exp_w = expected_words.pop_front();
                    if (i_out.item_value !== exp_w.item_value) begin
                        $error("item_value expected %0d got %0d", exp_w.item_value,
                            i_out.item_value);
                        errs++;
                    end
                    if (i_out.status !== exp_w.status) begin
                        $error("status expected %0d got %0d", exp_w.status, i_out.status);
                        errs++;
                    end
                    if (i_out.last !== exp_w.last) begin
                        $error("last expected %0d got %0d", exp_w.last, i_out.last);
                        errs++;
                    end
                end
            end
            if (i_start && !i_busy) apply_command(i_in);
            o_fail_count <= o_fail_count + errs;
        end
        o_pending <= expected_words.size();
    end
endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
    import cdll_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CAPACITY = 16;
    localparam int          IDLE_LIMIT = 20000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_in_word  i_in = '0;
    t_out_word o_out;
    logic      o_done;
    int        fail_count;
    int        pending;
    int        words_seen;
    int        idle_cycles = 0;
    int        sent = 0;
    logic signed [31:0] used_values [$];

    always #5 i_clk = ~i_clk;

    circular_doubly_linked_list_engine_top #(.CAPACITY(CAPACITY), .DATA_BITS(32)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_in(i_in), .o_out(o_out), .o_done(o_done)
    );

    cdll_checker #(.CAPACITY(CAPACITY)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_in(i_in), .i_out(o_out), .i_done(o_done),
        .o_fail_count(fail_count), .o_pending(pending), .o_words_seen(words_seen)
    );

    // watchdog on cycles with no accepted word and no result
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("circular_doubly_linked_list_engine_top regression: fail");
            $finish;
        end
    end

    // drop start and wait for a clock edge
    task automatic idle_input();
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return;
        start <= 1'b0;
        repeat (r < 9 ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge i_clk);
    endtask

    // send one command word and wait for acceptance
    task automatic send_word(t_op op, logic signed [31:0] v);
        start <= 1'b1;
        i_in  <= '{op: op, value: v};
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sent++;
        if (op == OP_CREATE || op == OP_INS_FRT || op == OP_INS_BCK) used_values.push_back(v);
    endtask

    function automatic logic signed [31:0] pick_value();
        if (used_values.size() != 0 && $urandom_range(0, 2) != 0)
            return used_values[$urandom_range(0, used_values.size() - 1)];
        return $urandom_range(0, 3) == 0 ? $urandom_range(0, 7) : $urandom();
    endfunction

    initial begin
        t_op op;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty cases, extremes, full pool, head guard
        send_word(OP_LIST, 0);
        send_word(OP_DEL_FRT, 0);
        send_word(OP_DEL_BCK, 0);
        send_word(OP_DEL_AFT, 0);
        send_word(OP_CLEAR, 0);
        send_word(OP_CREATE, 32'sh7fffffff);
        send_word(OP_DEL_AFT, 32'sh7fffffff);
        send_word(OP_INS_FRT, 32'sh80000000);
        send_word(OP_INS_BCK, -1);
        send_word(OP_LIST, 0);
        send_word(OP_DEL_AFT, 32'sh80000000);
        send_word(OP_DEL_AFT, 12345);
        send_word(OP_DEL_BCK, 0);
        send_word(OP_DEL_FRT, 0);
        for (int i = 0; i < 17; i++) send_word(OP_INS_BCK, i);
        send_word(OP_LIST, 0);
        send_word(OP_CLEAR, 0);
        send_word(OP_LIST, 0);

        // random commands, weighted toward inserts so lists grow deep
        for (int k = 0; k < 320; k++) begin
            if (k == 160) begin
                idle_input();
                wait (pending == 0);
            end
            case ($urandom_range(0, 15))
                0:             op = OP_CREATE;
                1, 2:          op = OP_LIST;
                3, 4, 5:       op = OP_INS_FRT;
                6, 7, 8, 9:    op = OP_INS_BCK;
                10:            op = OP_DEL_FRT;
                11:            op = OP_DEL_BCK;
                12, 13, 14:    op = OP_DEL_AFT;
                default:       op = ($urandom_range(0, 2) == 0) ? OP_CLEAR : OP_LIST;
            endcase
            send_word(op, pick_value());
            gap();
        end

        idle_input();
        wait (pending == 0);
        repeat (50) @(posedge i_clk);
        $display("sent %0d command words, checked %0d result words", sent, words_seen);
        $display("covered empty, full, not found and head guarded deletes");
        if (fail_count == 0) begin
            $display("circular_doubly_linked_list_engine_top regression: pass");
        end else begin
            $display("circular_doubly_linked_list_engine_top regression: fail");
        end
        $finish;
    end
endmodule
